// ===== hdl/wbr_pkg.sv =====
// ----------------------------------------------------------------------------
// Waypoint bearing and range: shared package
// Item types, pipeline stage type, CORDIC angle table and sizing constants.
// ----------------------------------------------------------------------------
package wbr_pkg;

   localparam int CORDIC_STAGES_DEF = 16;
   localparam int ROOT_STEPS        = 33;
   localparam int CORDIC_W          = 36;
   localparam int RADICAND_W        = 2 * ROOT_STEPS;
   localparam int REM_W             = 36;
   localparam logic [30:0] TOLERANCE_RESET = 31'd6554;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [15:0] heading;
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
   } req_type;

   typedef struct packed {
      logic signed [16:0] turn_angle;
      logic [32:0]        range_to_target;
      logic               reached;
   } rsp_type;

   typedef struct packed {
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic [31:0]                z;
      logic [RADICAND_W-1:0]      radicand;
      logic [REM_W-1:0]           rem;
      logic [ROOT_STEPS-1:0]      root;
      logic signed [15:0]         heading;
      logic                       reached;
      logic                       zero;
   } pipe_type;

   localparam logic [31:0] ATAN_TAB [32] = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
      32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
      32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
   };

endpackage

// ===== hdl/wbr_stage.sv =====
// ----------------------------------------------------------------------------
// Waypoint bearing and range: pipeline stage
// One square-root digit step and, in the first stages, one CORDIC rotation.
// ----------------------------------------------------------------------------
module wbr_stage #(
   parameter int STEP          = 0,
   parameter int CORDIC_STAGES = wbr_pkg::CORDIC_STAGES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  wbr_pkg::pipe_type in_pipe,
   output logic              out_valid,
   output wbr_pkg::pipe_type out_pipe
);

   logic                              valid_ff;
   wbr_pkg::pipe_type                 pipe_ff;
   wbr_pkg::pipe_type                 pipe_in;
   logic signed [wbr_pkg::CORDIC_W-1:0] rot_x;
   logic signed [wbr_pkg::CORDIC_W-1:0] rot_y;
   logic [31:0]                       rot_z;
   logic [wbr_pkg::REM_W-1:0]         rem_sh;
   logic [wbr_pkg::REM_W-1:0]         trial;

   if (STEP < CORDIC_STAGES && STEP < $size(wbr_pkg::ATAN_TAB)) begin : g_rot
      localparam logic [31:0] ANGLE = wbr_pkg::ATAN_TAB[STEP];
      logic signed [wbr_pkg::CORDIC_W-1:0] cx;
      logic signed [wbr_pkg::CORDIC_W-1:0] cy;
      logic signed [wbr_pkg::CORDIC_W-1:0] xs;
      logic signed [wbr_pkg::CORDIC_W-1:0] ys;
      always_comb begin
         cx = in_pipe.x;
         cy = in_pipe.y;
         xs = cx >>> STEP;
         ys = cy >>> STEP;
         if (!cy[wbr_pkg::CORDIC_W-1]) begin
            rot_x = cx + ys;
            rot_y = cy - xs;
            rot_z = in_pipe.z + ANGLE;
         end else begin
            rot_x = cx - ys;
            rot_y = cy + xs;
            rot_z = in_pipe.z - ANGLE;
         end
      end
   end else begin : g_pass
      assign rot_x = in_pipe.x;
      assign rot_y = in_pipe.y;
      assign rot_z = in_pipe.z;
   end

   always_comb begin
      pipe_in          = in_pipe;
      pipe_in.x        = rot_x;
      pipe_in.y        = rot_y;
      pipe_in.z        = rot_z;
      rem_sh           = {in_pipe.rem[wbr_pkg::REM_W-3:0],
                          in_pipe.radicand[wbr_pkg::RADICAND_W-1 -: 2]};
      trial            = {1'b0, in_pipe.root, 2'b01};
      pipe_in.radicand = {in_pipe.radicand[wbr_pkg::RADICAND_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
         pipe_in.rem  = rem_sh - trial;
         pipe_in.root = {in_pipe.root[wbr_pkg::ROOT_STEPS-2:0], 1'b1};
      end else begin
         pipe_in.rem  = rem_sh;
         pipe_in.root = {in_pipe.root[wbr_pkg::ROOT_STEPS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pipe_ff <= pipe_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_pipe  = pipe_ff;

endmodule

// ===== hdl/waypoint_bearing_and_range.sv =====
// ----------------------------------------------------------------------------
// Waypoint bearing and range
// Turn angle to a waypoint by vectoring CORDIC, exact floor distance by a
// digit-by-digit square root, and a per-axis reach test, fully pipelined.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake              Carries
//   req      in         req_valid / req_stall  pose and waypoint (req_type)
//   rsp      out        rsp_valid / rsp_stall  turn, range, reached (rsp_type)
//   csr      in         csr_valid / csr_ready  reach tolerance, Q16.16
//
// One item enters per cycle while req_stall is low. The pipeline has four front
// stages, 33 square-root digit stages that also carry the CORDIC rotations, one
// angle rounding stage and the output register.
// A skid register behind the output takes one item while rsp is stalled;
// req_stall is that register's full flag.
// Reset clears all valid bits and sets the tolerance to 6554.
// ----------------------------------------------------------------------------
module waypoint_bearing_and_range #(
   parameter int CORDIC_STAGES = wbr_pkg::CORDIC_STAGES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  wbr_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output wbr_pkg::rsp_type rsp_item,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [30:0]      csr_wdata
);

   typedef struct packed {
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic signed [15:0] heading;
   } diff_type;

   typedef struct packed {
      logic [31:0]                         ax;
      logic [31:0]                         ay;
      logic signed [wbr_pkg::CORDIC_W-1:0] x;
      logic signed [wbr_pkg::CORDIC_W-1:0] y;
      logic [31:0]                         z;
      logic signed [15:0]                  heading;
      logic                                reached;
      logic                                zero;
   } abs_type;

   typedef struct packed {
      logic [63:0]                         sq_x;
      logic [63:0]                         sq_y;
      logic signed [wbr_pkg::CORDIC_W-1:0] x;
      logic signed [wbr_pkg::CORDIC_W-1:0] y;
      logic [31:0]                         z;
      logic signed [15:0]                  heading;
      logic                                reached;
      logic                                zero;
   } square_type;

   logic [30:0]       tolerance_ff;
   logic              en;
   logic              a_valid_ff;
   diff_type          a_ff;
   diff_type          a_in;
   logic              b_valid_ff;
   abs_type           b_ff;
   abs_type           b_in;
   logic              c_valid_ff;
   square_type        c_ff;
   square_type        c_in;
   logic              d_valid_ff;
   wbr_pkg::pipe_type d_ff;
   wbr_pkg::pipe_type d_in;
   logic              s_valid [wbr_pkg::ROOT_STEPS+1];
   wbr_pkg::pipe_type s_pipe  [wbr_pkg::ROOT_STEPS+1];
   logic              f_valid_ff;
   wbr_pkg::rsp_type  f_ff;
   wbr_pkg::rsp_type  f_in;
   logic              out_valid_ff;
   wbr_pkg::rsp_type  out_ff;
   logic              skid_valid_ff;
   wbr_pkg::rsp_type  skid_ff;
   logic              out_take;

   logic signed [wbr_pkg::CORDIC_W-1:0] dx_w;
   logic signed [wbr_pkg::CORDIC_W-1:0] dy_w;
   logic [31:0]                         t_rnd;
   logic [15:0]                         r16;

   assign csr_ready = 1'b1;
   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign out_take  = out_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff <= wbr_pkg::TOLERANCE_RESET;
      end else if (csr_valid && csr_ready) begin
         tolerance_ff <= csr_wdata;
      end
   end

   always_comb begin
      a_in.dx      = 33'(req_item.target_x) - 33'(req_item.pos_x);
      a_in.dy      = 33'(req_item.target_y) - 33'(req_item.pos_y);
      a_in.heading = req_item.heading;
   end

   always_comb begin
      dx_w       = wbr_pkg::CORDIC_W'(a_ff.dx);
      dy_w       = wbr_pkg::CORDIC_W'(a_ff.dy);
      b_in.ax    = a_ff.dx[32] ? 32'(-a_ff.dx) : a_ff.dx[31:0];
      b_in.ay    = a_ff.dy[32] ? 32'(-a_ff.dy) : a_ff.dy[31:0];
      b_in.x     = a_ff.dx[32] ? -dx_w : dx_w;
      b_in.y     = a_ff.dx[32] ? -dy_w : dy_w;
      b_in.z     = a_ff.dx[32] ? 32'h80000000 : 32'h0;
      b_in.heading = a_ff.heading;
      b_in.zero  = (a_ff.dx == 33'sd0) && (a_ff.dy == 33'sd0);
      b_in.reached = (b_in.ax < {1'b0, tolerance_ff}) && (b_in.ay < {1'b0, tolerance_ff});
   end

   always_comb begin
      c_in.sq_x    = 64'(b_ff.ax) * 64'(b_ff.ax);
      c_in.sq_y    = 64'(b_ff.ay) * 64'(b_ff.ay);
      c_in.x       = b_ff.x;
      c_in.y       = b_ff.y;
      c_in.z       = b_ff.z;
      c_in.heading = b_ff.heading;
      c_in.reached = b_ff.reached;
      c_in.zero    = b_ff.zero;
   end

   always_comb begin
      d_in.x        = c_ff.x;
      d_in.y        = c_ff.y;
      d_in.z        = c_ff.z;
      d_in.radicand = wbr_pkg::RADICAND_W'(c_ff.sq_x) + wbr_pkg::RADICAND_W'(c_ff.sq_y);
      d_in.rem      = '0;
      d_in.root     = '0;
      d_in.heading  = c_ff.heading;
      d_in.reached  = c_ff.reached;
      d_in.zero     = c_ff.zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         f_valid_ff <= s_valid[wbr_pkg::ROOT_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff <= a_in;
         b_ff <= b_in;
         c_ff <= c_in;
         d_ff <= d_in;
         f_ff <= f_in;
      end
   end

   assign s_valid[0] = d_valid_ff;
   assign s_pipe[0]  = d_ff;

   for (genvar i = 0; i < wbr_pkg::ROOT_STEPS; i++) begin : g_step
      wbr_stage #(
         .STEP          (i),
         .CORDIC_STAGES (CORDIC_STAGES)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (s_valid[i]),
         .in_pipe   (s_pipe[i]),
         .out_valid (s_valid[i+1]),
         .out_pipe  (s_pipe[i+1])
      );
   end

   always_comb begin
      t_rnd = s_pipe[wbr_pkg::ROOT_STEPS].z
              - {s_pipe[wbr_pkg::ROOT_STEPS].heading, 16'h0000} + 32'h00008000;
      r16   = t_rnd[31:16];
      if (s_pipe[wbr_pkg::ROOT_STEPS].zero) begin
         f_in.turn_angle = '0;
      end else if (r16 == 16'h8000) begin
         f_in.turn_angle = {1'b0, r16};
      end else begin
         f_in.turn_angle = {r16[15], r16};
      end
      f_in.range_to_target = s_pipe[wbr_pkg::ROOT_STEPS].root;
      f_in.reached         = s_pipe[wbr_pkg::ROOT_STEPS].reached;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (f_valid_ff) begin
         if (out_valid_ff && !out_take) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (out_take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_take) begin
            out_ff <= skid_ff;
         end
      end else if (f_valid_ff) begin
         if (out_valid_ff && !out_take) begin
            skid_ff <= f_ff;
         end else begin
            out_ff <= f_ff;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;

endmodule

// ===== hdl/wbr_checker.sv =====
// ----------------------------------------------------------------------------
// Waypoint bearing and range: port checker
// Watches the top level's ports and flags results that cannot be right.
// ----------------------------------------------------------------------------
module wbr_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input wbr_pkg::rsp_type rsp_item
);

   // A stalled result must hold until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("stalled result changed");

   // The input is only held off while a result is waiting.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result waiting");

   // A zero range means coincident points, which give a zero turn.
   a_zero_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.range_to_target == 33'd0) |-> (rsp_item.turn_angle == 17'sd0))
      else $error("nonzero turn at zero range");

   // A half turn is always reported as the positive value.
   a_half_turn: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.turn_angle[16:15] != 2'b10) && (rsp_item.turn_angle != -17'sd32768))
      else $error("turn angle out of range");

   // Both offsets below a 31-bit tolerance bound the range below 2^32.
   a_reached_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.reached |-> !rsp_item.range_to_target[32])
      else $error("reached with an impossible range");

endmodule

bind waypoint_bearing_and_range wbr_checker u_wbr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);
